// ----- hw/rtl/mlk_pkg.sv -----
// ----------------------------------------------------------------------------
// mlk_pkg
// shared types, character codes, register indexes and the letter table
// ----------------------------------------------------------------------------
package mlk_pkg;

  localparam int CHAR_W    = 8;
  localparam int PULSE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_GAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP   = 3'd4;

  // one job for the pulse sequencer
  typedef struct packed {
    logic       word;      // space after a letter: word gap only
    logic       gap;       // letter gap before the elements
    logic [2:0] len;       // element count, 1..4
    logic [3:0] pattern;   // element i in bit i, 1 is a dash
  } cmd_t;

  // element count in bits 6..4, elements in bits 3..0
  function automatic logic [6:0] letter_code(input logic [4:0] idx);
    logic [6:0] code;
    unique case (idx)
      5'd0:  code = 7'h22;
      5'd1:  code = 7'h41;
      5'd2:  code = 7'h45;
      5'd3:  code = 7'h31;
      5'd4:  code = 7'h10;
      5'd5:  code = 7'h44;
      5'd6:  code = 7'h33;
      5'd7:  code = 7'h40;
      5'd8:  code = 7'h20;
      5'd9:  code = 7'h4E;
      5'd10: code = 7'h35;
      5'd11: code = 7'h42;
      5'd12: code = 7'h23;
      5'd13: code = 7'h21;
      5'd14: code = 7'h37;
      5'd15: code = 7'h46;
      5'd16: code = 7'h4B;
      5'd17: code = 7'h32;
      5'd18: code = 7'h30;
      5'd19: code = 7'h11;
      5'd20: code = 7'h34;
      5'd21: code = 7'h48;
      5'd22: code = 7'h36;
      5'd23: code = 7'h49;
      5'd24: code = 7'h4D;
      5'd25: code = 7'h43;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/mlk_front.sv -----
// ----------------------------------------------------------------------------
// mlk_front
// takes characters, folds case, looks up letters and queues sequencer jobs
// ----------------------------------------------------------------------------
module mlk_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mlk_pkg::CHAR_W-1:0] char_code,
  output logic                       push,
  output mlk_pkg::cmd_t              push_cmd,
  input  logic                       queue_full
);
  import mlk_pkg::*;

  logic              prev_was_letter;
  logic              prev_was_letter_next;
  logic [CHAR_W-1:0] folded;
  logic [CHAR_W-1:0] letter_off;
  logic [6:0]        code;
  logic              is_space;
  logic              is_letter;
  logic              take;

  assign in_stall = queue_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    is_space = (char_code == CHAR_SPACE);
    folded   = char_code;
    if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
      folded = char_code - CASE_OFFSET;
    end
    is_letter  = (folded >= CHAR_UPPER_A) && (folded <= CHAR_UPPER_Z);
    letter_off = folded - CHAR_UPPER_A;
    code       = letter_code(letter_off[4:0]);
  end

  always_comb begin
    push_cmd.word    = is_space;
    push_cmd.gap     = prev_was_letter;
    push_cmd.len     = code[6:4];
    push_cmd.pattern = code[3:0];
    push                 = 1'b0;
    prev_was_letter_next = prev_was_letter;
    if (take) begin
      if (is_space) begin
        push                 = prev_was_letter;
        prev_was_letter_next = 1'b0;
      end else if (is_letter) begin
        push                 = 1'b1;
        prev_was_letter_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_letter <= 1'b0;
    end else begin
      prev_was_letter <= prev_was_letter_next;
    end
  end

endmodule

// ----- hw/rtl/mlk_queue.sv -----
// ----------------------------------------------------------------------------
// mlk_queue
// two-entry job queue between the front and the pulse sequencer
// ----------------------------------------------------------------------------
module mlk_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mlk_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mlk_pkg::cmd_t head_cmd
);
  import mlk_pkg::*;

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/mlk_back.sv -----
// ----------------------------------------------------------------------------
// mlk_back
// duration registers and pulse sequencer with a registered output stage
// ----------------------------------------------------------------------------
module mlk_back #(
  parameter int DURATION_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mlk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlk_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           head_valid,
  input  mlk_pkg::cmd_t                  head_cmd,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           led_level,
  output logic [mlk_pkg::PULSE_W-1:0]    pulse_ticks,
  output logic                           last_pulse
);
  import mlk_pkg::*;

  logic [DURATION_WIDTH-1:0] dot_ticks;
  logic [DURATION_WIDTH-1:0] dash_ticks;
  logic [DURATION_WIDTH-1:0] element_gap_ticks;
  logic [DURATION_WIDTH-1:0] letter_gap_ticks;
  logic [DURATION_WIDTH-1:0] word_gap_ticks;

  logic [DURATION_WIDTH+CFG_DATA_W-1:0] wdata_ext;
  logic [DURATION_WIDTH+PULSE_W-1:0]    dur_ext;
  logic [DURATION_WIDTH-1:0]            dur_sel;
  logic [DURATION_WIDTH-1:0]            wdata;

  // sequencer position inside the current job
  logic       gap_done;
  logic       gap_done_next;
  logic       half;
  logic       half_next;
  logic [1:0] idx;
  logic [1:0] idx_next;

  logic       load_ok;
  logic       fire;
  logic       is_dash;
  logic       elem_last;
  logic       led_next;
  logic       last_next;

  // register values are kept in DURATION_WIDTH bits
  assign wdata_ext = {{DURATION_WIDTH{1'b0}}, cfg_data};
  assign wdata     = wdata_ext[DURATION_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks         <= DURATION_WIDTH'(1);
      dash_ticks        <= DURATION_WIDTH'(3);
      element_gap_ticks <= DURATION_WIDTH'(1);
      letter_gap_ticks  <= DURATION_WIDTH'(2);
      word_gap_ticks    <= DURATION_WIDTH'(6);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOT:        dot_ticks         <= wdata;
        REG_DASH:       dash_ticks        <= wdata;
        REG_ELEM_GAP:   element_gap_ticks <= wdata;
        REG_LETTER_GAP: letter_gap_ticks  <= wdata;
        REG_WORD_GAP:   word_gap_ticks    <= wdata;
        default: ;
      endcase
    end
  end

  assign load_ok   = !out_valid || !out_stall;
  assign fire      = load_ok && head_valid;
  assign is_dash   = head_cmd.pattern[idx];
  assign elem_last = ({1'b0, idx} == (head_cmd.len - 3'd1));

  always_comb begin
    gap_done_next = gap_done;
    half_next     = half;
    idx_next      = idx;
    pop           = 1'b0;
    led_next      = 1'b0;
    last_next     = 1'b0;
    dur_sel       = element_gap_ticks;
    if (head_cmd.word) begin
      dur_sel   = word_gap_ticks;
      last_next = 1'b1;
      pop       = fire;
    end else if (head_cmd.gap && !gap_done) begin
      dur_sel = letter_gap_ticks;
      if (fire) begin
        gap_done_next = 1'b1;
      end
    end else if (!half) begin
      led_next = 1'b1;
      dur_sel  = is_dash ? dash_ticks : dot_ticks;
      if (fire) begin
        half_next = 1'b1;
      end
    end else begin
      last_next = elem_last;
      if (fire) begin
        half_next = 1'b0;
        if (elem_last) begin
          pop           = 1'b1;
          idx_next      = '0;
          gap_done_next = 1'b0;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
    end
  end

  assign dur_ext = {{PULSE_W{1'b0}}, dur_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_done  <= 1'b0;
      half      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      gap_done <= gap_done_next;
      half     <= half_next;
      idx      <= idx_next;
      if (load_ok) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      led_level   <= led_next;
      pulse_ticks <= dur_ext[PULSE_W-1:0];
      last_pulse  <= last_next;
    end
  end

endmodule

// ----- hw/rtl/morse_letter_keyer.sv -----
// ----------------------------------------------------------------------------
// morse_letter_keyer
// letters-only morse keyer: ascii characters in, led on/off pulses out
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid / in_stall     char_code[7:0]
//  out       out_valid / out_stall   led_level, pulse_ticks[15:0], last_pulse
//  cfg       cfg_valid / cfg_ready   cfg_index[2:0], cfg_data[15:0]
//
//  one pulse leaves the sequencer per cycle while a job waits and out_stall does
//  not hold it; a letter gives 2 to 9 pulses (letter gap plus two pulses per
//  element) and a word gap gives one; characters that give no pulse queue no job.
//  the sequencer output register sets the rate; the front keeps taking
//  characters while the two-entry job queue has room.
//  reset clears the letter flag, the queue, the sequencer and out_valid, and
//  loads the default durations; cfg_ready is always high.
//  in_stall is high while the job queue is full; out_stall holds the pulse.
// ----------------------------------------------------------------------------
module morse_letter_keyer #(
  parameter int DURATION_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // character input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mlk_pkg::CHAR_W-1:0]     char_code,
  // pulse output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           led_level,
  output logic [mlk_pkg::PULSE_W-1:0]    pulse_ticks,
  output logic                           last_pulse,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mlk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlk_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mlk_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // writes are always taken, one per cycle
  assign cfg_ready = 1'b1;

  // front: case folding, table lookup, letter flag
  mlk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  // job queue decouples character transfers from pulse transfers
  mlk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: duration registers and pulse sequencer
  mlk_back #(
    .DURATION_WIDTH (DURATION_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_level   (led_level),
    .pulse_ticks (pulse_ticks),
    .last_pulse  (last_pulse)
  );

endmodule

// ----- hw/rtl/mlk_checker.sv -----
// ----------------------------------------------------------------------------
// mlk_checker
// port-level checks on the keyer output stream
// ----------------------------------------------------------------------------
module mlk_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        led_level,
  input logic [mlk_pkg::PULSE_W-1:0] pulse_ticks,
  input logic                        last_pulse
);
  import mlk_pkg::*;

  logic out_xfer;
  logic on_pending;

  assign out_xfer = out_valid && !out_stall;

  // an on pulse was the last transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      on_pending <= 1'b0;
    end else if (out_xfer) begin
      on_pending <= led_level;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(led_level) &&
    $stable(pulse_ticks) && $stable(last_pulse))
    else $error("stalled pulse changed");

  a_on_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_level |-> !last_pulse)
    else $error("on pulse marked as last");

  a_off_after_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && on_pending |-> !led_level)
    else $error("on pulse not followed by off pulse");

endmodule

bind morse_letter_keyer mlk_checker u_mlk_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .led_level   (led_level),
  .pulse_ticks (pulse_ticks),
  .last_pulse  (last_pulse)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for morse_letter_keyer
// characters go in on a valid/stall channel, led pulses come back out on a
// second one; a behavioral keyer in the bench predicts every pulse and each
// pulse transfer is compared field by field against the oldest prediction.
// a short table of hand-picked characters runs first, then random text under
// several duration settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  import mlk_pkg::*;

  localparam int PHASE_KEYED      = 64;    // characters that give pulses, per setting
  localparam int SETTLE_CYCLES    = 20;    // a full letter job plus queue slack
  localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no transfer at all
  localparam int LONG_HOLD_AT     = 200;   // characters in before the long hold
  localparam int LONG_HOLD_CYCLES = 300;

  // out-of-range register writes start right after the last real index
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_WORD_GAP + 3'd1;

  typedef struct packed {
    logic               led;
    logic [PULSE_W-1:0] ticks;
    logic               last;
  } pulse_t;

  localparam pulse_t NO_PULSE = '0;

  // one row of the directed table; when typed is set the pulses are written
  // out in the row, otherwise the keyer model supplies them
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              typed;
    logic [1:0]        n;
    pulse_t            p0;
    pulse_t            p1;
    pulse_t            p2;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     char_code  = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic                  led_level;
  logic [PULSE_W-1:0]    pulse_ticks;
  logic                  last_pulse;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  always #4 clk = ~clk;

  morse_letter_keyer DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_level   (led_level),
    .pulse_ticks (pulse_ticks),
    .last_pulse  (last_pulse),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // --------------------------------------------------------------------------
  // keyer model: its own copy of the durations and the letter flag
  // --------------------------------------------------------------------------
  string morse_tab [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  logic [PULSE_W-1:0] dur [5];
  logic               after_letter;
  pulse_t             keyed [$];           // pulses of the character just taken
  pulse_t             pending_pulses [$];  // pulses still owed by the block

  function automatic pulse_t pl(input int led, input int t, input int last);
    return {1'(led), PULSE_W'(t), 1'(last)};
  endfunction

  function automatic void add_pulse(input logic led, input logic [PULSE_W-1:0] t);
    keyed.push_back({led, t, 1'b0});
  endfunction

  function automatic void key_character(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    string             code;
    pulse_t            tail;
    keyed.delete();
    if (ch == CHAR_SPACE) begin
      // only a space that closes a word keys anything
      if (after_letter) begin
        add_pulse(1'b0, dur[REG_WORD_GAP]);
        after_letter = 1'b0;
      end
    end else begin
      up = (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ? ch - CASE_OFFSET : ch;
      if (up >= CHAR_UPPER_A && up <= CHAR_UPPER_Z) begin
        if (after_letter) add_pulse(1'b0, dur[REG_LETTER_GAP]);
        code = morse_tab[up - CHAR_UPPER_A];
        for (int i = 0; i < code.len(); i++) begin
          add_pulse(1'b1, (code[i] == "-") ? dur[REG_DASH] : dur[REG_DOT]);
          add_pulse(1'b0, dur[REG_ELEM_GAP]);
        end
        after_letter = 1'b1;
      end
      // anything else leaves the flag alone
    end
    if (keyed.size() != 0) begin
      tail = keyed.pop_back();
      tail.last = 1'b1;
      keyed.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // run bookkeeping
  // --------------------------------------------------------------------------
  int chars_taken   = 0;
  int chars_keyed   = 0;
  int pulses_seen   = 0;
  int reg_writes    = 0;
  int settings_used = 1;  // the reset defaults count as the first
  int mismatches    = 0;
  int idle_cycles   = 0;

  // stall generator state, owned by its process
  int hold_left      = 0;
  int mode_left      = 0;
  bit stall_quiet    = 1'b0;
  bit long_hold_done = 1'b0;

  stim_row_t plan [$];
  bit        quiet;
  int        item;
  int        phase_keyed;
  logic [CHAR_W-1:0] ch;

  // --------------------------------------------------------------------------
  // character side
  // --------------------------------------------------------------------------

  // offer one character and return at the edge of its transfer; valid is left
  // high so a back-to-back character can follow without a bubble
  task automatic offer_char(input logic [CHAR_W-1:0] c);
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    chars_taken++;
    key_character(c);
  endtask

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(input bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_in(input int n);
    if (n > 0) begin
      in_valid  <= 1'b0;
      char_code <= CHAR_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // letters of either case most of the time, spaces, and some junk bytes
  function automatic logic [CHAR_W-1:0] pick_char();
    int                r;
    logic [CHAR_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      c = CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
    end else if (r < 85) begin
      c = CHAR_SPACE;
    end else begin
      do c = CHAR_W'($urandom);
      while (c == CHAR_SPACE || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z));
    end
    return c;
  endfunction

  // random text until enough characters have produced pulses
  task automatic run_text();
    phase_keyed = 0;
    item        = 0;
    while (phase_keyed < PHASE_KEYED) begin
      // every so often switch between gappy and back-to-back stretches
      if (item % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      ch = pick_char();
      offer_char(ch);
      foreach (keyed[i]) pending_pulses.push_back(keyed[i]);
      if (keyed.size() != 0) begin
        phase_keyed++;
        chars_keyed++;
      end
      idle_in(pick_gap(quiet));
      item++;
    end
  endtask

  // drop valid, wait for every owed pulse, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // register side
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_WORD_GAP) dur[idx] = val;
    reg_writes++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CFG_DATA_W'(1);
    return CFG_DATA_W'($urandom_range(2, 65534));
  endfunction

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] dot_t, dash_t, elem_t,
                               letter_t, word_t);
    settle();
    write_reg(REG_DOT, dot_t);
    write_reg(REG_DASH, dash_t);
    // an index past the last register must not disturb anything
    write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    write_reg(REG_ELEM_GAP, elem_t);
    write_reg(REG_LETTER_GAP, letter_t);
    write_reg(REG_WORD_GAP, word_t);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // pulse side: random stalls, one long hold to back the block up
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && chars_taken >= LONG_HOLD_AT) begin
      // the sender keeps going meanwhile, so the job queue fills and in_stall rises
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_quiet = ($urandom_range(0, 3) == 0);
        mode_left   = 64;
      end
      mode_left--;
      if (stall_quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
      end else begin
        hold_left  = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end
    end
  end

  // compare each pulse transfer with the oldest owed pulse
  always @(posedge clk) begin : pulse_check
    pulse_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pulses.size() == 0) begin
        $error("pulse transfer with nothing owed: led_level %0d pulse_ticks %0d last_pulse %0d",
               led_level, pulse_ticks, last_pulse);
        mismatches++;
      end else begin
        want = pending_pulses.pop_front();
        pulses_seen++;
        if (led_level !== want.led) begin
          $error("led_level: expected %0d, got %0d", want.led, led_level);
          mismatches++;
        end
        if (pulse_ticks !== want.ticks) begin
          $error("pulse_ticks: expected %0d, got %0d", want.ticks, pulse_ticks);
          mismatches++;
        end
        if (last_pulse !== want.last) begin
          $error("last_pulse: expected %0d, got %0d", want.last, last_pulse);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles, %0d pulses still owed",
             idle_cycles, pending_pulses.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    dur[REG_DOT]        = 16'd1;
    dur[REG_DASH]       = 16'd3;
    dur[REG_ELEM_GAP]   = 16'd1;
    dur[REG_LETTER_GAP] = 16'd2;
    dur[REG_WORD_GAP]   = 16'd6;
    after_letter        = 1'b0;

    // directed table, all at the reset durations (dot 1, dash 3, gaps 1/2/6)
    plan.push_back({8'h45, 1'b1, 2'd2, pl(1, 1, 0), pl(0, 1, 1), NO_PULSE});  // E
    plan.push_back({CHAR_SPACE, 1'b1, 2'd1, pl(0, 6, 1), NO_PULSE, NO_PULSE});
    // a second space in a row keys nothing
    plan.push_back({CHAR_SPACE, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h74, 1'b1, 2'd2, pl(1, 3, 0), pl(0, 1, 1), NO_PULSE});  // t
    plan.push_back({8'h65, 1'b1, 2'd3, pl(0, 2, 0), pl(1, 1, 0), pl(0, 1, 1)});  // e
    // junk bytes are dropped and keep the letter flag
    plan.push_back({8'h00, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'hFF, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h54, 1'b1, 2'd3, pl(0, 2, 0), pl(1, 3, 0), pl(0, 1, 1)});  // T
    // just outside the letter ranges, and a digit
    plan.push_back({8'h30, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h40, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h5B, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h60, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h7B, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    // range ends in both cases, the longest letters
    plan.push_back({CHAR_UPPER_A, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({CHAR_UPPER_Z, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({CHAR_LOWER_A, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({CHAR_LOWER_Z, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h51, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});  // Q, nine pulses
    plan.push_back({CHAR_SPACE, 1'b1, 2'd1, pl(0, 6, 1), NO_PULSE, NO_PULSE});
    plan.push_back({8'h48, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});  // H, no letter gap
    plan.push_back({8'h80, 1'b1, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});
    plan.push_back({8'h4A, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});  // J
    plan.push_back({CHAR_SPACE, 1'b1, 2'd1, pl(0, 6, 1), NO_PULSE, NO_PULSE});
    plan.push_back({8'h69, 1'b0, 2'd0, NO_PULSE, NO_PULSE, NO_PULSE});  // i

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      offer_char(plan[r].ch);
      if (plan[r].typed) begin
        if (plan[r].n > 0) pending_pulses.push_back(plan[r].p0);
        if (plan[r].n > 1) pending_pulses.push_back(plan[r].p1);
        if (plan[r].n > 2) pending_pulses.push_back(plan[r].p2);
      end else begin
        foreach (keyed[i]) pending_pulses.push_back(keyed[i]);
      end
      if (keyed.size() != 0) chars_keyed++;
      idle_in(pick_gap(1'b0));
    end

    // random text at the defaults, then at each extreme, then mixed settings
    run_text();
    apply_setting('0, '0, '0, '0, '0);
    run_text();
    apply_setting('1, '1, '1, '1, '1);
    run_text();
    repeat (2) begin
      apply_setting(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      run_text();
    end

    settle();

    $display("run: %0d characters sent, %0d of them keyed, %0d pulses checked",
             chars_taken, chars_keyed, pulses_seen);
    $display("run: %0d register writes over %0d duration settings, %0d mismatches",
             reg_writes, settings_used, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- morse_letter_keyer.f -----
hw/rtl/mlk_pkg.sv
hw/rtl/mlk_front.sv
hw/rtl/mlk_queue.sv
hw/rtl/mlk_back.sv
hw/rtl/morse_letter_keyer.sv
hw/rtl/mlk_checker.sv
sim/tb.sv
